FILE: hdl/dsmm_pkg.sv
// Shared constants, types and state encoding for the dependency set merge block.
package dsmm_pkg;

	localparam int CAPACITY = 64;
	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam int KEY_W = 16;
	localparam int TYPE_W = 8;
	localparam int SLOT_OUT_W = 6;
	localparam int COUNT_OUT_W = 7;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TYPE_W-1:0] dtype;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE
	} state_t;

endpackage

FILE: hdl/dependency_set_max_merge_core.sv
// Top level: dependency set with max-merge of types, held in one synchronous memory.
// Each item is looked up by a linear scan of the entry memory and then resolved; a stalled
// result holds the next item at the end of its scan, in the resolve state.
// A new item is taken only once the previous one has been resolved; the scan runs
// through the single read port of the entry memory, one slot per cycle.
// Reset clears the fill count and all control state; memory contents are not cleared.
module dependency_set_max_merge_core
	import dsmm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  logic [KEY_W-1:0]       var_index,
	input  logic [TYPE_W-1:0]      dep_type,
	output logic                   result_valid,
	input  logic                   result_ready,
	output logic                   was_present,
	output logic [SLOT_OUT_W-1:0]  slot,
	output logic [TYPE_W-1:0]      stored_type,
	output logic [COUNT_OUT_W-1:0] entry_count,
	output logic                   overflow
);

	entry_t mem [CAPACITY];

	state_t state_q, state_d;

	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  rd_addr_q;
	logic [KEY_W-1:0]  idx_q;
	logic [TYPE_W-1:0] typ_q;
	logic              hit_q;
	logic [SLOT_W-1:0] hit_slot_q;
	logic [TYPE_W-1:0] hit_type_q;

	logic              rd_vld_s1;
	logic [SLOT_W-1:0] rd_slot_s1;
	entry_t            rd_data_s1;

	logic                   out_valid_q;
	logic                   out_present_q;
	logic [SLOT_OUT_W-1:0]  out_slot_q;
	logic [TYPE_W-1:0]      out_type_q;
	logic [COUNT_OUT_W-1:0] out_count_q;
	logic                   out_ovf_q;

	logic              item_accept;
	logic              issue;
	logic              rd_match;
	logic              scan_miss;
	logic              out_free;
	logic              resolve_go;
	logic              full;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic [TYPE_W-1:0] new_type;

	assign full = (fill_q == CNT_W'(CAPACITY));
	assign out_free = !out_valid_q || result_ready;
	assign item_accept = item_valid && item_ready;
	assign rd_match = rd_vld_s1 && (rd_data_s1.key == idx_q);
	assign new_type = (hit_q && (hit_type_q >= typ_q)) ? hit_type_q : typ_q;
	assign wr_addr = hit_q ? hit_slot_q : fill_q[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		item_ready = 1'b0;
		issue = 1'b0;
		scan_miss = 1'b0;
		resolve_go = 1'b0;
		wr_en = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				issue = (rd_addr_q < fill_q);
				scan_miss = !rd_vld_s1 && (rd_addr_q == fill_q);
				if (rd_match || scan_miss) begin
					state_d = ST_RESOLVE;
				end
			end
			ST_RESOLVE: begin
				resolve_go = out_free;
				wr_en = out_free && (hit_q ? (typ_q > hit_type_q) : !full);
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{key: idx_q, dtype: typ_q};
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_addr_q[SLOT_W-1:0]];
			rd_slot_s1 <= rd_addr_q[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
			rd_addr_q <= '0;
			fill_q <= '0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (item_accept) begin
				rd_addr_q <= '0;
				hit_q <= 1'b0;
			end else if (issue) begin
				rd_addr_q <= rd_addr_q + CNT_W'(1);
			end
			if (state_q == ST_SCAN && rd_match) begin
				hit_q <= 1'b1;
			end
			if (resolve_go && !hit_q && !full) begin
				fill_q <= fill_q + CNT_W'(1);
			end
			if (resolve_go) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			idx_q <= var_index;
			typ_q <= dep_type;
		end
		if (state_q == ST_SCAN && rd_match) begin
			hit_slot_q <= rd_slot_s1;
			hit_type_q <= rd_data_s1.dtype;
		end
		if (resolve_go) begin
			out_present_q <= hit_q;
			out_ovf_q <= !hit_q && full;
			if (hit_q) begin
				out_slot_q <= SLOT_OUT_W'(hit_slot_q);
				out_type_q <= new_type;
				out_count_q <= COUNT_OUT_W'(fill_q);
			end else if (full) begin
				out_slot_q <= '0;
				out_type_q <= '0;
				out_count_q <= COUNT_OUT_W'(fill_q);
			end else begin
				out_slot_q <= SLOT_OUT_W'(fill_q);
				out_type_q <= typ_q;
				out_count_q <= COUNT_OUT_W'(fill_q + CNT_W'(1));
			end
		end
	end

	assign result_valid = out_valid_q;
	assign was_present = out_present_q;
	assign slot = out_slot_q;
	assign stored_type = out_type_q;
	assign entry_count = out_count_q;
	assign overflow = out_ovf_q;

endmodule

FILE: hdl/dsmm_checker.sv
// Port-level checker for the dependency set merge block, bound to the top level.
module dsmm_checker
	import dsmm_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   item_valid,
	input logic                   item_ready,
	input logic [KEY_W-1:0]       var_index,
	input logic [TYPE_W-1:0]      dep_type,
	input logic                   result_valid,
	input logic                   result_ready,
	input logic                   was_present,
	input logic [SLOT_OUT_W-1:0]  slot,
	input logic [TYPE_W-1:0]      stored_type,
	input logic [COUNT_OUT_W-1:0] entry_count,
	input logic                   overflow
);

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_ready |=> item_valid && $stable(var_index) && $stable(dep_type))
		else $error("item dropped before acceptance");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(slot)
			&& $stable(stored_type) && $stable(entry_count) && $stable(overflow)
			&& $stable(was_present))
		else $error("stalled result changed");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("second item taken while one is in flight");

	a_overflow_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && overflow |-> !was_present && slot == '0 && stored_type == '0
			&& entry_count == COUNT_OUT_W'(CAPACITY))
		else $error("overflow result malformed");

	a_hit_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && was_present |-> !overflow)
		else $error("hit reported together with overflow");

endmodule

bind dependency_set_max_merge_core dsmm_checker u_dsmm_checker (.*);
